// ----- sv/pbwa_pkg.sv -----
// Shared types and constants for the PCI BAR window allocator.
`default_nettype none

package pbwa_pkg;

    localparam int ADDR_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 3;

    localparam logic [ADDR_W-1:0] RST_WINDOW_BASE  = 32'h1000_0000;
    localparam logic [ADDR_W-1:0] RST_WINDOW_LIMIT = 32'h3EFF_0000;
    localparam logic [ADDR_W-1:0] ADDR_FIELD_MASK  = 32'hFFFF_FFF0;

    // Memory type code in bits 2:1 of a memory BAR that marks a 64-bit slot.
    localparam logic [1:0] MEM_TYPE_64 = 2'b10;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 2'd1;

    typedef enum logic [2:0] {
        ACT_IO       = 3'd0,
        ACT_UPPER    = 3'd1,
        ACT_UNIMPL   = 3'd2,
        ACT_NOSPACE  = 3'd3,
        ACT_ASSIGNED = 3'd4,
        ACT_RESTART  = 3'd5
    } action_t;

    typedef struct packed {
        logic              kind;
        logic              first_of_device;
        logic [ADDR_W-1:0] bar_value;
        logic [ADDR_W-1:0] size_readback;
    } item_t;

    typedef struct packed {
        action_t           action;
        logic [ADDR_W-1:0] assigned_address;
        logic              clear_upper;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] next_free;
        logic              upper_pending;
    } alloc_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] window_base;
        logic [ADDR_W-1:0] window_limit;
    } window_cfg_t;

endpackage

`default_nettype wire

// ----- sv/pci_bar_window_allocator.sv -----
// Top level of the PCI BAR window allocator: request and result registers around the placer.
`default_nettype none

// Places BAR slots into a 32-bit memory window with a bump pointer. Each request
// is one slot (original value and all-ones readback) or a restart, and yields
// exactly one result in order. A request is registered on acceptance; its result
// (add, align and limit compare on the held free pointer) is registered once the
// result register is free, so one request is taken every cycle unless m_tready
// stalls the output. The user must write window bounds through the cfg port while
// idle, which the block does not enforce; a new base takes effect at restart.
module pci_bar_window_allocator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Slave side: tdata = bar_value[31:0], size_readback[63:32];
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pbwa_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser = kind[0], first_of_device[1]
    input  wire logic [pbwa_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Master side: tdata = assigned_address[31:0], clear_upper[32], zero[39:33]
    output logic [pbwa_pkg::OUT_DATA_W-1:0]         m_tdata,
    // tuser = action[2:0]
    output logic [pbwa_pkg::OUT_USER_W-1:0]         m_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pbwa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pbwa_pkg::ADDR_W-1:0]        cfg_data
);
    import pbwa_pkg::*;

    window_cfg_t  window;
    item_t        item_reg;
    logic         item_valid_reg;
    alloc_state_t state_reg;
    alloc_state_t state_next;
    result_t      result_next;
    result_t      result_reg;
    logic         out_valid_reg;
    logic         out_free;
    logic         advance;

    pbwa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .window    (window)
    );

    pbwa_slot_calc u_calc (
        .item       (item_reg),
        .state_cur  (state_reg),
        .window     (window),
        .result     (result_next),
        .state_next (state_next)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = item_valid_reg && out_free;
    assign s_tready = !item_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg          <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.next_free     <= RST_WINDOW_BASE;
            state_reg.upper_pending <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                item_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= item_valid_reg;
            end
            // Allocator state moves only when a request retires into the result register.
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.kind            <= s_tuser[0];
            item_reg.first_of_device <= s_tuser[1];
            item_reg.bar_value       <= s_tdata[ADDR_W-1:0];
            item_reg.size_readback   <= s_tdata[2*ADDR_W-1:ADDR_W];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.action;
    assign m_tdata  = {{(OUT_DATA_W-ADDR_W-1){1'b0}}, result_reg.clear_upper,
                       result_reg.assigned_address};

endmodule

`default_nettype wire

// ----- sv/pbwa_cfg_regs.sv -----
// Configuration registers holding the allocation window bounds.
`default_nettype none

module pbwa_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pbwa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pbwa_pkg::ADDR_W-1:0]    cfg_data,
    output pbwa_pkg::window_cfg_t              window
);
    import pbwa_pkg::*;

    window_cfg_t window_reg;

    assign cfg_ready = 1'b1;
    assign window    = window_reg;

    // Writes to indexes past the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg.window_base  <= RST_WINDOW_BASE;
            window_reg.window_limit <= RST_WINDOW_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_WINDOW_BASE)
            begin
                window_reg.window_base <= cfg_data;
            end
            else if (cfg_index == CFG_WINDOW_LIMIT)
            begin
                window_reg.window_limit <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/pbwa_slot_calc.sv -----
// Placement logic for one BAR slot: alignment, limit check and pointer bump.
`default_nettype none

module pbwa_slot_calc (
    input  pbwa_pkg::item_t        item,
    input  pbwa_pkg::alloc_state_t state_cur,
    input  pbwa_pkg::window_cfg_t  window,
    output pbwa_pkg::result_t      result,
    output pbwa_pkg::alloc_state_t state_next
);
    import pbwa_pkg::*;

    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W:0]   bumped;
    logic [ADDR_W:0]   aligned;
    logic [ADDR_W+1:0] region_end;
    logic              is64;

    // size - 1 equals ~mask, so rounding up is one add and an AND with the mask.
    assign mask       = item.size_readback & ADDR_FIELD_MASK;
    assign size       = ~mask + {{(ADDR_W-1){1'b0}}, 1'b1};
    assign bumped     = {1'b0, state_cur.next_free} + {1'b0, ~mask};
    assign aligned    = bumped & {1'b1, mask};
    assign region_end = {1'b0, aligned} + {2'b00, size};
    assign is64       = (item.bar_value[2:1] == MEM_TYPE_64);

    always_comb
    begin
        result.action           = ACT_IO;
        result.assigned_address = '0;
        result.clear_upper      = 1'b0;
        state_next              = state_cur;

        if (item.kind)
        begin
            state_next.next_free     = window.window_base;
            state_next.upper_pending = 1'b0;
            result.action            = ACT_RESTART;
        end
        else if (state_cur.upper_pending && !item.first_of_device)
        begin
            state_next.upper_pending = 1'b0;
            result.action            = ACT_UPPER;
        end
        else if (item.bar_value[0])
        begin
            state_next.upper_pending = 1'b0;
            result.action            = ACT_IO;
        end
        else
        begin
            // A 64-bit slot marks its successor even when it is not placed.
            state_next.upper_pending = is64;
            if (mask == '0)
            begin
                result.action = ACT_UNIMPL;
            end
            else if (region_end > {2'b00, window.window_limit})
            begin
                result.action = ACT_NOSPACE;
            end
            else
            begin
                state_next.next_free    = region_end[ADDR_W-1:0];
                result.action           = ACT_ASSIGNED;
                result.assigned_address = aligned[ADDR_W-1:0];
                result.clear_upper      = is64;
            end
        end
    end

endmodule

`default_nettype wire
